// ===== design/rlf_pkg.sv =====
// Shared types, codes and defaults for the run-length FIFO with bulk take.
package rlf_pkg;

   localparam int unsigned DEF_RUN_DEPTH  = 1024;
   localparam int unsigned DEF_VALUE_BITS = 32;
   localparam int unsigned DEF_COUNT_BITS = 32;

   localparam int unsigned FIELD_BITS  = 32;
   localparam int unsigned SUM_BITS    = 64;
   localparam int unsigned STATUS_BITS = 2;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TAKE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDER = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic accept_push;
      logic accept_take;
      logic rd_issue;
      logic run_update;
      logic sum_add;
      logic set_under;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic want_zero;
      logic occ_zero;
   } stat_type;

endpackage

// ===== design/rlf_ctrl.sv =====
// Sequencer for push and take transfers of the run-length FIFO.
module rlf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rlf_pkg::stat_type stat,
   output rlf_pkg::cmd_type  cmd
);

   rlf_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == rlf_pkg::REQ_TAKE) ? rlf_pkg::ST_CHECK
                                                          : rlf_pkg::ST_FIN;
            end
         end
         rlf_pkg::ST_CHECK: begin
            if (stat.want_zero || stat.occ_zero) begin
               state_in = rlf_pkg::ST_FIN;
            end else begin
               state_in = rlf_pkg::ST_MUL;
            end
         end
         rlf_pkg::ST_MUL: state_in = rlf_pkg::ST_ADD;
         rlf_pkg::ST_ADD: state_in = rlf_pkg::ST_CHECK;
         rlf_pkg::ST_FIN: begin
            if (rsp_free) begin
               state_in = rlf_pkg::ST_IDLE;
            end
         end
         default: state_in = rlf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rlf_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.accept_push = req_valid && (req_type == rlf_pkg::REQ_PUSH);
            cmd.accept_take = req_valid && (req_type == rlf_pkg::REQ_TAKE);
         end
         rlf_pkg::ST_CHECK: begin
            cmd.rd_issue  = !stat.want_zero && !stat.occ_zero;
            cmd.set_under = !stat.want_zero && stat.occ_zero;
         end
         rlf_pkg::ST_MUL: cmd.run_update = 1'b1;
         rlf_pkg::ST_ADD: cmd.sum_add = 1'b1;
         rlf_pkg::ST_FIN: cmd.rsp_load = rsp_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/rlf_dp.sv =====
// Run store, queue pointers, multiply and saturating accumulate.
module rlf_dp #(
   parameter int unsigned RUN_DEPTH  = rlf_pkg::DEF_RUN_DEPTH,
   parameter int unsigned VALUE_BITS = rlf_pkg::DEF_VALUE_BITS,
   parameter int unsigned COUNT_BITS = rlf_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rlf_pkg::cmd_type                    cmd,
   output rlf_pkg::stat_type                   stat,
   input  logic [rlf_pkg::FIELD_BITS-1:0]      req_run_value,
   input  logic [rlf_pkg::FIELD_BITS-1:0]      req_unit_count,
   output logic [rlf_pkg::SUM_BITS-1:0]        rsp_taken_sum,
   output logic [rlf_pkg::STATUS_BITS-1:0]     rsp_status
);

   localparam int unsigned AW = $clog2(RUN_DEPTH);
   localparam int unsigned OW = $clog2(RUN_DEPTH + 1);
   localparam int unsigned EW = VALUE_BITS + COUNT_BITS;

   logic [EW-1:0] mem [RUN_DEPTH];

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [COUNT_BITS-1:0] want_ff, want_in;
   logic [EW-1:0] rd_data_ff;
   logic [EW-1:0] prod_ff;
   logic [rlf_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [rlf_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [rlf_pkg::SUM_BITS-1:0] rsp_sum_ff;
   logic [rlf_pkg::STATUS_BITS-1:0] rsp_status_ff;

   logic [VALUE_BITS-1:0] in_value, rd_value;
   logic [COUNT_BITS-1:0] in_count, rd_count, units;
   logic full, push_write, part_take;
   logic [AW-1:0] head_next, tail_next;
   logic [rlf_pkg::SUM_BITS:0] sum_wide;

   assign in_value   = req_run_value[VALUE_BITS-1:0];
   assign in_count   = req_unit_count[COUNT_BITS-1:0];
   assign rd_value   = rd_data_ff[EW-1:COUNT_BITS];
   assign rd_count   = rd_data_ff[COUNT_BITS-1:0];
   assign full       = (occ_ff == OW'(RUN_DEPTH));
   assign push_write = cmd.accept_push && (in_count != '0) && !full;
   assign part_take  = (rd_count > want_ff);
   assign units      = part_take ? want_ff : rd_count;
   assign head_next  = (head_ff == AW'(RUN_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign tail_next  = (tail_ff == AW'(RUN_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign sum_wide   = {1'b0, sum_ff}
                     + {{(rlf_pkg::SUM_BITS + 1 - EW){1'b0}}, prod_ff};

   assign stat.want_zero = (want_ff == '0);
   assign stat.occ_zero  = (occ_ff == '0);

   assign rsp_taken_sum = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      want_in   = want_ff;
      sum_in    = sum_ff;
      status_in = status_ff;
      if (cmd.accept_push) begin
         sum_in    = '0;
         status_in = (in_count != '0 && full) ? rlf_pkg::STATUS_FULL : rlf_pkg::STATUS_OK;
      end
      if (push_write) begin
         tail_in = tail_next;
         occ_in  = occ_ff + OW'(1);
      end
      if (cmd.accept_take) begin
         want_in   = in_count;
         sum_in    = '0;
         status_in = rlf_pkg::STATUS_OK;
      end
      if (cmd.run_update) begin
         if (part_take) begin
            want_in = '0;
         end else begin
            want_in = want_ff - rd_count;
            head_in = head_next;
            occ_in  = occ_ff - OW'(1);
         end
      end
      if (cmd.sum_add) begin
         sum_in = sum_wide[rlf_pkg::SUM_BITS] ? '1 : sum_wide[rlf_pkg::SUM_BITS-1:0];
      end
      if (cmd.set_under) begin
         status_in = rlf_pkg::STATUS_UNDER;
      end
   end

   always_ff @(posedge clock) begin
      if (push_write) begin
         mem[tail_ff] <= {in_value, in_count};
      end else if (cmd.run_update && part_take) begin
         mem[head_ff] <= {rd_value, rd_count - want_ff};
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff   <= want_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      if (cmd.run_update) begin
         prod_ff <= EW'(rd_value) * EW'(units);
      end
      if (cmd.rsp_load) begin
         rsp_sum_ff    <= sum_ff;
         rsp_status_ff <= status_ff;
      end
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(RUN_DEPTH))
      else $error("occupancy beyond depth");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.run_update |-> rd_count != '0)
      else $error("stored run with zero count");

   a_take_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.run_update |=> occ_ff <= $past(occ_ff))
      else $error("take grew the queue");

   a_under_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.set_under |-> (occ_ff == '0 && want_ff != '0))
      else $error("underflow flagged with runs left");
`endif

endmodule

// ===== design/run_length_fifo_bulk_take_sum.sv =====
// Run-length FIFO of (value, count) runs: a push appends a run, a take removes
// units from the oldest runs and returns their saturating weighted sum with a
// status. One request is handled at a time. A push passes through the finish
// state into the response register. A take loops through store read,
// multiply and accumulate steps once per run it touches, so its time follows
// the number of runs consumed. The response register lets the next request
// transfer in while a finished result still waits to be taken.
module run_length_fifo_bulk_take_sum #(
   parameter int unsigned RUN_DEPTH  = rlf_pkg::DEF_RUN_DEPTH,
   parameter int unsigned VALUE_BITS = rlf_pkg::DEF_VALUE_BITS,
   parameter int unsigned COUNT_BITS = rlf_pkg::DEF_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [rlf_pkg::FIELD_BITS-1:0]  req_run_value,
   input  logic [rlf_pkg::FIELD_BITS-1:0]  req_unit_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rlf_pkg::SUM_BITS-1:0]    rsp_taken_sum,
   output logic [rlf_pkg::STATUS_BITS-1:0] rsp_status
);

   rlf_pkg::cmd_type  cmd;
   rlf_pkg::stat_type stat;

   rlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlf_dp #(
      .RUN_DEPTH  (RUN_DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_run_value  (req_run_value),
      .req_unit_count (req_unit_count),
      .rsp_taken_sum  (rsp_taken_sum),
      .rsp_status     (rsp_status)
   );

endmodule
